/* src/fbld_pkg.sv */
// Shared types and constants for the framebuffer line drawer.
`timescale 1ns / 1ps

package fbld_pkg;

	// Screen columns; every 7-bit column lies on the screen.
	localparam int SCREEN_WIDTH = 128;

	localparam int COORD_W = 7;
	localparam int INDEX_W = 10;
	localparam int BYTE_W = 8;
	localparam int ROW_W = 8;
	localparam int ERR_W = 17;
	localparam int ERR0_W = 10;
	localparam int DX2_W = 8;
	localparam int DY2_W = 9;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_PIXEL = 2'd1,
		REQ_LINE  = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_CLEAR,
		K_PIXEL,
		K_HLINE,
		K_VLINE,
		K_SLOPE,
		K_READ,
		K_READ_OFF
	} kind_t;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_CLEAR,
		ST_DRAW,
		ST_READ,
		ST_FLUSH,
		ST_RESP
	} state_t;

	typedef struct packed {
		kind_t                     kind;
		logic                      on;
		logic [COORD_W-1:0]        x0;
		logic [COORD_W-1:0]        y0;
		logic [COORD_W-1:0]        x1;
		logic [COORD_W-1:0]        y1;
		logic signed [ERR0_W-1:0]  err0;
		logic [DX2_W-1:0]          dx2;
		logic signed [DY2_W-1:0]   dy2;
		logic [INDEX_W-1:0]        rd_index;
	} cmd_t;

endpackage

/* src/framebuffer_line_drawer_unit.sv */
// Top level of the framebuffer line drawer: request decoder, queue and drawing engine.
`timescale 1ns / 1ps

// A 128-column monochrome framebuffer held as pages of column bytes, where
// bit (row mod 8) of a byte holds one pixel. Each request on the cmd channel
// (cmd_valid/cmd_ready) is one command: clear the store, set or clear one
// pixel, draw a white line, or read one store byte. Every request yields
// exactly one result on the res channel (res_valid/res_ready); read_byte and
// is_read carry the byte for a read and are zero for other commands.
// A request is decoded on entry and waits in a two-entry queue; the drawing
// engine then touches one pixel per cycle through a read-modify-write on the
// single-port-write frame store. A line steps along its columns (or the rows
// of a vertical run), and a clear writes zero to every store byte, that is
// 128 * ceil(SCREEN_HEIGHT / 8) bytes (1024 at the default height).
// After reset the engine runs the same clearing pass over the store, and
// cmd_ready stays low until that pass is done.
// When the receiver holds res_ready low, the finished result waits in the
// output register while the engine goes on with the next queued request;
// once that one is also done the engine waits, and the queue then fills and
// drops cmd_ready.
module framebuffer_line_drawer_unit #(
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [1:0]                    req_type,
	input  logic [fbld_pkg::COORD_W-1:0]  start_x,
	input  logic [fbld_pkg::COORD_W-1:0]  start_y,
	input  logic [fbld_pkg::COORD_W-1:0]  end_x,
	input  logic [fbld_pkg::COORD_W-1:0]  end_y,
	input  logic                          pixel_on,
	input  logic [fbld_pkg::INDEX_W-1:0]  byte_index,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [fbld_pkg::BYTE_W-1:0]   read_byte,
	output logic                          is_read
);

	fbld_pkg::cmd_t dec_cmd;
	fbld_pkg::cmd_t head_cmd;
	logic q_full;
	logic q_avail;
	logic q_pop;
	logic booting;

	// Requests are refused while the queue is full or the store is being
	// cleared after reset.
	assign cmd_ready = !q_full && !booting;

	fbld_front #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.req_type  (req_type),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.pixel_on  (pixel_on),
		.byte_index(byte_index),
		.cmd       (dec_cmd)
	);

	fbld_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_valid && cmd_ready),
		.push_cmd(dec_cmd),
		.pop     (q_pop),
		.full    (q_full),
		.avail   (q_avail),
		.head    (head_cmd)
	);

	fbld_back #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_avail(q_avail),
		.cmd      (head_cmd),
		.cmd_pop  (q_pop),
		.booting  (booting),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.read_byte(read_byte),
		.is_read  (is_read)
	);

endmodule

/* src/fbld_front.sv */
// Front end: decodes a request into a drawing command with its line setup.
`timescale 1ns / 1ps

module fbld_front #(
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic [1:0]                    req_type,
	input  logic [fbld_pkg::COORD_W-1:0]  start_x,
	input  logic [fbld_pkg::COORD_W-1:0]  start_y,
	input  logic [fbld_pkg::COORD_W-1:0]  end_x,
	input  logic [fbld_pkg::COORD_W-1:0]  end_y,
	input  logic                          pixel_on,
	input  logic [fbld_pkg::INDEX_W-1:0]  byte_index,
	output fbld_pkg::cmd_t                cmd
);

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = PAGES * fbld_pkg::SCREEN_WIDTH;

	logic signed [7:0] dx;
	logic signed [7:0] dy;

	assign dx = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
	assign dy = signed'({1'b0, end_y}) - signed'({1'b0, start_y});

	always_comb begin
		cmd.on = pixel_on;
		cmd.x0 = start_x;
		cmd.y0 = start_y;
		cmd.x1 = end_x;
		cmd.y1 = end_y;
		cmd.err0 = signed'({dy[7], dy, 1'b0}) - signed'({{2{dx[7]}}, dx});
		cmd.dx2 = {dx[6:0], 1'b0};
		cmd.dy2 = signed'({dy, 1'b0});
		cmd.rd_index = byte_index;
		cmd.kind = fbld_pkg::K_NOP;
		unique case (fbld_pkg::req_t'(req_type))
			fbld_pkg::REQ_CLEAR: begin
				cmd.kind = fbld_pkg::K_CLEAR;
			end
			fbld_pkg::REQ_PIXEL: begin
				if ({1'b0, start_y} < 8'(SCREEN_HEIGHT)) begin
					cmd.kind = fbld_pkg::K_PIXEL;
				end
			end
			fbld_pkg::REQ_LINE: begin
				// Runs drawn backward produce nothing at all.
				if (dy == 8'sd0) begin
					if (end_x >= start_x) cmd.kind = fbld_pkg::K_HLINE;
				end else if (dx == 8'sd0) begin
					if (end_y >= start_y) cmd.kind = fbld_pkg::K_VLINE;
				end else if (end_x > start_x) begin
					cmd.kind = fbld_pkg::K_SLOPE;
				end
			end
			fbld_pkg::REQ_READ: begin
				if ({1'b0, byte_index} < 11'(DEPTH)) begin
					cmd.kind = fbld_pkg::K_READ;
				end else begin
					cmd.kind = fbld_pkg::K_READ_OFF;
				end
			end
			default: begin
				cmd.kind = fbld_pkg::K_NOP;
			end
		endcase
	end

endmodule

/* src/fbld_queue.sv */
// Two-entry command queue between the decoder and the drawing engine.
`timescale 1ns / 1ps

module fbld_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbld_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           avail,
	output fbld_pkg::cmd_t head
);

	fbld_pkg::cmd_t entry_q [fbld_pkg::QUEUE_DEPTH];
	logic [fbld_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [fbld_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [fbld_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == fbld_pkg::QCNT_W'(fbld_pkg::QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

/* src/fbld_back.sv */
// Back end: frame store, sweep clear, pixel read-modify-write and result register.
`timescale 1ns / 1ps

module fbld_back #(
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_avail,
	input  fbld_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          booting,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [fbld_pkg::BYTE_W-1:0]   read_byte,
	output logic                          is_read
);

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = PAGES * fbld_pkg::SCREEN_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ERR_W = fbld_pkg::ERR_W;

	fbld_pkg::state_t state_q, state_d;

	// Command being worked on.
	fbld_pkg::kind_t kind_q;
	logic [fbld_pkg::COORD_W-1:0] x_q;
	logic [fbld_pkg::ROW_W-1:0] y_q;
	logic [fbld_pkg::COORD_W-1:0] x_end_q;
	logic [fbld_pkg::COORD_W-1:0] y_end_q;
	logic set_q;
	logic signed [ERR_W-1:0] err_q;
	logic [fbld_pkg::DX2_W-1:0] dx2_q;
	logic signed [fbld_pkg::DY2_W-1:0] dy2_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [fbld_pkg::BYTE_W-1:0] res_byte_q;
	logic res_rd_q;

	logic [ADDR_W-1:0] sweep_q;
	logic sweep_last;

	// Frame store and its read pipeline.
	logic [fbld_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [fbld_pkg::BYTE_W-1:0] mem_rd_q;
	logic op_vld_s1;
	logic op_rd_s1;
	logic [ADDR_W-1:0] op_addr_s1;
	logic [fbld_pkg::BYTE_W-1:0] op_mask_s1;
	logic op_set_s1;
	logic last_wr_vld_q;
	logic [ADDR_W-1:0] last_wr_addr_q;
	logic [fbld_pkg::BYTE_W-1:0] last_wr_data_q;

	logic res_valid_q;
	logic [fbld_pkg::BYTE_W-1:0] read_byte_q;
	logic is_read_q;

	// Control outputs of the sequencer.
	logic op_vld;
	logic op_rd;
	logic [ADDR_W-1:0] op_addr;
	logic sweep_wr;
	logic advance;
	logic load_res;

	logic pt_on_screen;
	logic [fbld_pkg::INDEX_W-1:0] pt_index;
	logic pt_last;
	logic err_pos;
	logic signed [ERR_W-1:0] dy2_ext;
	logic signed [ERR_W-1:0] dx2_ext;

	logic [fbld_pkg::BYTE_W-1:0] base_byte;
	logic [fbld_pkg::BYTE_W-1:0] new_byte;
	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [fbld_pkg::BYTE_W-1:0] wr_data;

	assign sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));
	assign pt_on_screen = (y_q < fbld_pkg::ROW_W'(SCREEN_HEIGHT));
	assign pt_index = {y_q[5:3], x_q};
	assign err_pos = !err_q[ERR_W-1] && (err_q != '0);
	assign dy2_ext = {{(ERR_W - fbld_pkg::DY2_W){dy2_q[fbld_pkg::DY2_W-1]}}, dy2_q};
	assign dx2_ext = signed'({{(ERR_W - fbld_pkg::DX2_W){1'b0}}, dx2_q});

	always_comb begin
		unique case (kind_q)
			fbld_pkg::K_HLINE, fbld_pkg::K_SLOPE: pt_last = (x_q == x_end_q);
			fbld_pkg::K_VLINE: pt_last = (y_q[fbld_pkg::COORD_W-1:0] == y_end_q);
			default: pt_last = 1'b1;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbld_pkg::ST_BOOT: begin
				if (sweep_last) state_d = fbld_pkg::ST_IDLE;
			end
			fbld_pkg::ST_CLEAR: begin
				if (sweep_last) state_d = fbld_pkg::ST_RESP;
			end
			fbld_pkg::ST_IDLE: begin
				if (cmd_avail) begin
					unique case (cmd.kind)
						fbld_pkg::K_CLEAR: state_d = fbld_pkg::ST_CLEAR;
						fbld_pkg::K_PIXEL, fbld_pkg::K_HLINE, fbld_pkg::K_VLINE,
						fbld_pkg::K_SLOPE: state_d = fbld_pkg::ST_DRAW;
						fbld_pkg::K_READ: state_d = fbld_pkg::ST_READ;
						default: state_d = fbld_pkg::ST_RESP;
					endcase
				end
			end
			fbld_pkg::ST_DRAW: begin
				if (pt_last) state_d = fbld_pkg::ST_FLUSH;
			end
			fbld_pkg::ST_READ: begin
				state_d = fbld_pkg::ST_FLUSH;
			end
			fbld_pkg::ST_FLUSH: begin
				state_d = fbld_pkg::ST_RESP;
			end
			fbld_pkg::ST_RESP: begin
				if (!res_valid_q || res_ready) state_d = fbld_pkg::ST_IDLE;
			end
			default: begin
				state_d = fbld_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd_pop = 1'b0;
		op_vld = 1'b0;
		op_rd = 1'b0;
		op_addr = pt_index[ADDR_W-1:0];
		sweep_wr = 1'b0;
		advance = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			fbld_pkg::ST_BOOT, fbld_pkg::ST_CLEAR: begin
				sweep_wr = 1'b1;
			end
			fbld_pkg::ST_IDLE: begin
				cmd_pop = cmd_avail;
			end
			fbld_pkg::ST_DRAW: begin
				op_vld = pt_on_screen;
				advance = 1'b1;
			end
			fbld_pkg::ST_READ: begin
				op_vld = 1'b1;
				op_rd = 1'b1;
				op_addr = rd_addr_q;
			end
			fbld_pkg::ST_RESP: begin
				load_res = !res_valid_q || res_ready;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	assign booting = (state_q == fbld_pkg::ST_BOOT);

	// A write made in the cycle of this op's read is not in the read data yet.
	assign base_byte = (last_wr_vld_q && (last_wr_addr_q == op_addr_s1)) ?
		last_wr_data_q : mem_rd_q;
	assign new_byte = op_set_s1 ? (base_byte | op_mask_s1) : (base_byte & ~op_mask_s1);
	assign wr_en = sweep_wr || (op_vld_s1 && !op_rd_s1);
	assign wr_addr = sweep_wr ? sweep_q : op_addr_s1;
	assign wr_data = sweep_wr ? '0 : new_byte;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (op_vld) mem_rd_q <= mem[op_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbld_pkg::ST_BOOT;
			sweep_q <= '0;
			op_vld_s1 <= 1'b0;
			last_wr_vld_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweep_wr) sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			op_vld_s1 <= op_vld;
			last_wr_vld_q <= wr_en;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_rd_s1 <= op_rd;
		op_addr_s1 <= op_addr;
		op_mask_s1 <= fbld_pkg::BYTE_W'(1) << y_q[2:0];
		op_set_s1 <= set_q;
		last_wr_addr_q <= wr_addr;
		last_wr_data_q <= wr_data;

		if (cmd_pop) begin
			kind_q <= cmd.kind;
			x_q <= cmd.x0;
			y_q <= {1'b0, cmd.y0};
			x_end_q <= cmd.x1;
			y_end_q <= cmd.y1;
			set_q <= (cmd.kind == fbld_pkg::K_PIXEL) ? cmd.on : 1'b1;
			err_q <= {{(ERR_W - fbld_pkg::ERR0_W){cmd.err0[fbld_pkg::ERR0_W-1]}}, cmd.err0};
			dx2_q <= cmd.dx2;
			dy2_q <= cmd.dy2;
			rd_addr_q <= cmd.rd_index[ADDR_W-1:0];
			res_byte_q <= '0;
			res_rd_q <= (cmd.kind == fbld_pkg::K_READ) || (cmd.kind == fbld_pkg::K_READ_OFF);
		end else if (advance) begin
			unique case (kind_q)
				fbld_pkg::K_HLINE: begin
					x_q <= x_q + 1'b1;
				end
				fbld_pkg::K_VLINE: begin
					y_q <= y_q + 1'b1;
				end
				fbld_pkg::K_SLOPE: begin
					x_q <= x_q + 1'b1;
					if (err_pos) begin
						y_q <= y_q + 1'b1;
						err_q <= err_q + dy2_ext - dx2_ext;
					end else begin
						err_q <= err_q + dy2_ext;
					end
				end
				default: begin
					x_q <= x_q;
				end
			endcase
		end

		if (op_vld_s1 && op_rd_s1) res_byte_q <= base_byte;

		if (load_res) begin
			read_byte_q <= res_byte_q;
			is_read_q <= res_rd_q;
		end
	end

	assign res_valid = res_valid_q;
	assign read_byte = read_byte_q;
	assign is_read = is_read_q;

endmodule

/* test/fbld_response_checker.sv */
// Checker for the framebuffer line drawer: shadow frame, expected responses and comparison.
`timescale 1ns / 1ps

module fbld_response_checker #(
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  logic                          cmd_ready,
	input  logic [1:0]                    req_type,
	input  logic [fbld_pkg::COORD_W-1:0]  start_x,
	input  logic [fbld_pkg::COORD_W-1:0]  start_y,
	input  logic [fbld_pkg::COORD_W-1:0]  end_x,
	input  logic [fbld_pkg::COORD_W-1:0]  end_y,
	input  logic                          pixel_on,
	input  logic [fbld_pkg::INDEX_W-1:0]  byte_index,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [fbld_pkg::BYTE_W-1:0]   read_byte,
	input  logic                          is_read,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int STORE_BYTES = 1024;

	typedef struct packed {
		logic [fbld_pkg::BYTE_W-1:0] data;
		logic                        is_read;
	} response_t;

	logic [fbld_pkg::BYTE_W-1:0] shadow_frame [0:STORE_BYTES-1];
	response_t                   owed_responses [$];
	int                          error_total = 0;
	int                          owed_count = 0;

	assign mismatches = error_total;
	assign outstanding = owed_count;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		error_total++;
	endtask

	function automatic void paint_pixel(input int x, input int y, input bit on);
		int at;
		logic [fbld_pkg::BYTE_W-1:0] bitmask;
		if (x >= fbld_pkg::SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
			return;
		end
		at = (x + ((y >> 3) << 7)) & (STORE_BYTES - 1);
		bitmask = fbld_pkg::BYTE_W'(1 << (y & 7));
		if (on) begin
			shadow_frame[at] = shadow_frame[at] | bitmask;
		end else begin
			shadow_frame[at] = shadow_frame[at] & ~bitmask;
		end
	endfunction

	// Sloped lines step over columns only; the row moves up by one while the
	// error term is positive, so falling and steep lines come out flat or short.
	function automatic void rasterize_line(input int xa, input int ya, input int xb, input int yb);
		int dx;
		int dy;
		int err;
		int x;
		int y;
		dx = xb - xa;
		dy = yb - ya;
		if (dy == 0) begin
			for (x = xa; x <= xb; x++) paint_pixel(x, ya, 1'b1);
		end else if (dx == 0) begin
			for (y = ya; y <= yb; y++) paint_pixel(xa, y, 1'b1);
		end else begin
			err = 2 * dy - dx;
			y = ya;
			for (x = xa; x <= xb; x++) begin
				paint_pixel(x, y, 1'b1);
				if (err > 0) begin
					y++;
					err -= 2 * dx;
				end
				err += 2 * dy;
			end
		end
	endfunction

	function automatic response_t render_request(input logic [1:0] op, input int sx, input int sy,
			input int ex, input int ey, input bit on, input int idx);
		response_t resp;
		resp = '0;
		case (op)
			fbld_pkg::REQ_CLEAR: begin
				foreach (shadow_frame[i]) shadow_frame[i] = '0;
			end
			fbld_pkg::REQ_PIXEL: begin
				paint_pixel(sx, sy, on);
			end
			fbld_pkg::REQ_LINE: begin
				rasterize_line(sx, sy, ex, ey);
			end
			default: begin
				resp.data = shadow_frame[idx & (STORE_BYTES - 1)];
				resp.is_read = 1'b1;
			end
		endcase
		return resp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			foreach (shadow_frame[i]) shadow_frame[i] = '0;
			owed_responses.delete();
		end else begin
			// A response can never belong to the request taken on the same edge,
			// so the response side is settled first.
			if (res_valid && res_ready) begin
				if (owed_responses.size() == 0) begin
					report_mismatch("response with none expected, read_byte", read_byte, -1);
				end else begin
					want = owed_responses.pop_front();
					if (read_byte !== want.data) begin
						report_mismatch("read_byte", read_byte, want.data);
					end
					if (is_read !== want.is_read) begin
						report_mismatch("is_read", is_read, want.is_read);
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				owed_responses.push_back(render_request(req_type, start_x, start_y, end_x, end_y,
					pixel_on, byte_index));
			end
		end
		owed_count = owed_responses.size();
	end

endmodule

/* test/tb_framebuffer_line_drawer_unit.sv */
// Testbench top for the framebuffer line drawer: request stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module tb_framebuffer_line_drawer_unit;

	// Roughly 1100 random requests follow the directed ones.
	localparam int RANDOM_ITEMS = 1100;
	// The long response hold-off starts once this many requests have gone in,
	// and lasts long enough to outlast even a full store clear in flight.
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 1500;
	// Slowest legal run: every request a full store clear plus the longest
	// sender gap and receiver stall, plus the boot clear, taken several times.
	localparam int unsigned CYCLE_LIMIT = 5000000;
	// Idle time after the last response before the verdict is given.
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]                   op;
		logic [fbld_pkg::COORD_W-1:0] sx;
		logic [fbld_pkg::COORD_W-1:0] sy;
		logic [fbld_pkg::COORD_W-1:0] ex;
		logic [fbld_pkg::COORD_W-1:0] ey;
		logic                         on;
		logic [fbld_pkg::INDEX_W-1:0] idx;
	} drawer_req_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cmd_valid;
	logic                         cmd_ready;
	logic [1:0]                   req_type;
	logic [fbld_pkg::COORD_W-1:0] start_x;
	logic [fbld_pkg::COORD_W-1:0] start_y;
	logic [fbld_pkg::COORD_W-1:0] end_x;
	logic [fbld_pkg::COORD_W-1:0] end_y;
	logic                         pixel_on;
	logic [fbld_pkg::INDEX_W-1:0] byte_index;
	logic                         res_valid;
	logic                         res_ready;
	logic [fbld_pkg::BYTE_W-1:0]  read_byte;
	logic                         is_read;

	int                 mismatches;
	int                 outstanding;
	int                 items_sent = 0;
	int unsigned        cycle_count = 0;

	// The last coordinate that was drawn, so that reads often land on live bytes.
	int                 last_x = 0;
	int                 last_y = 0;

	drawer_req_t        directed_reqs [$];

	framebuffer_line_drawer_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.req_type   (req_type),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pixel_on   (pixel_on),
		.byte_index (byte_index),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.read_byte  (read_byte),
		.is_read    (is_read)
	);

	fbld_response_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_on    (pixel_on),
		.byte_index  (byte_index),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.read_byte   (read_byte),
		.is_read     (is_read),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// Hard stop in case the block hangs; this also catches responses that
	// never arrive, since the end of the run waits for all of them.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("framebuffer_line_drawer_unit: mismatch");
			$finish;
		end
	end

	function automatic drawer_req_t req_of(input logic [1:0] op, input int sx, input int sy,
			input int ex, input int ey, input bit on, input int idx);
		drawer_req_t r;
		r.op = op;
		r.sx = fbld_pkg::COORD_W'(sx);
		r.sy = fbld_pkg::COORD_W'(sy);
		r.ex = fbld_pkg::COORD_W'(ex);
		r.ey = fbld_pkg::COORD_W'(ey);
		r.on = on;
		r.idx = fbld_pkg::INDEX_W'(idx);
		return r;
	endfunction

	// Offers one request from the current falling edge and holds it until it is
	// taken, then returns on the next falling edge with valid still high. The
	// caller either offers the next request right away or drops valid.
	task automatic drive_request(input drawer_req_t r);
		cmd_valid  <= 1'b1;
		req_type   <= r.op;
		start_x    <= r.sx;
		start_y    <= r.sy;
		end_x      <= r.ex;
		end_y      <= r.ey;
		pixel_on   <= r.on;
		byte_index <= r.idx;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	// Rows mostly stay on screen, with one request in eight reaching the
	// clipped rows 64..127.
	function automatic int pick_row();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 63);
	endfunction

	// Random request with every field filled, then shaped by command kind.
	// Lines are mostly well formed (forward runs, gentle rising slopes); the
	// rest are backward, falling, steep or fully random.
	task automatic make_random_request(output drawer_req_t r);
		int pick;
		int shape;
		int span;
		logic [fbld_pkg::COORD_W-1:0] swap;
		r.sx = fbld_pkg::COORD_W'($urandom);
		r.sy = fbld_pkg::COORD_W'($urandom);
		r.ex = fbld_pkg::COORD_W'($urandom);
		r.ey = fbld_pkg::COORD_W'($urandom);
		r.on = 1'($urandom);
		r.idx = fbld_pkg::INDEX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			r.op = fbld_pkg::REQ_CLEAR;
		end else if (pick < 32) begin
			r.op = fbld_pkg::REQ_PIXEL;
			r.sy = fbld_pkg::COORD_W'(pick_row());
			last_x = r.sx;
			last_y = r.sy;
		end else if (pick < 62) begin
			r.op = fbld_pkg::REQ_LINE;
			shape = $urandom_range(0, 9);
			if (shape <= 8) begin
				r.sy = fbld_pkg::COORD_W'(pick_row());
			end
			if (shape <= 2) begin
				// Horizontal run.
				r.ey = r.sy;
				if (r.ex < r.sx && $urandom_range(0, 7) != 0) begin
					swap = r.sx;
					r.sx = r.ex;
					r.ex = swap;
				end
			end else if (shape <= 4) begin
				// Vertical run.
				r.ex = r.sx;
				r.ey = fbld_pkg::COORD_W'(pick_row());
				if (r.ey < r.sy && $urandom_range(0, 7) != 0) begin
					swap = r.sy;
					r.sy = r.ey;
					r.ey = swap;
				end
			end else if (shape <= 8) begin
				// Sloped line, usually no steeper than 45 degrees.
				if (r.ex < r.sx && $urandom_range(0, 7) != 0) begin
					swap = r.sx;
					r.sx = r.ex;
					r.ex = swap;
				end
				if (r.ex > r.sx && $urandom_range(0, 5) != 0) begin
					span = $urandom_range(0, r.ex - r.sx);
					r.ey = fbld_pkg::COORD_W'((r.sy + span > 127) ? 127 : r.sy + span);
				end
			end
			last_x = r.sx;
			last_y = r.sy;
		end else begin
			r.op = fbld_pkg::REQ_READ;
			if (last_y < 64 && $urandom_range(0, 1) == 0) begin
				r.idx = fbld_pkg::INDEX_W'(((last_y >> 3) << 7) + last_x);
			end
		end
	endtask

	// Receiver: stretches of no stalls or of sparse, heavy or alternating stalls, plus a
	// single long hold-off while the sender keeps pushing, which fills the
	// request queue and must pull cmd_ready low.
	initial begin : receiver
		int span;
		int mode;
		bit held;
		res_ready = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!held && items_sent >= HOLD_AT) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(1, 50);
				repeat (span) begin
					case (mode)
						0: res_ready <= 1'b1;
						1: res_ready <= ($urandom_range(0, 3) != 0);
						2: res_ready <= ($urandom_range(0, 3) == 0);
						default: res_ready <= ~res_ready;
					endcase
					@(negedge clk);
				end
			end
		end
	end

	initial begin : sender
		drawer_req_t r;
		int burst;
		int total;
		int i;

		cmd_valid  = 1'b0;
		req_type   = fbld_pkg::REQ_CLEAR;
		start_x    = '0;
		start_y    = '0;
		end_x      = '0;
		end_y      = '0;
		pixel_on   = 1'b0;
		byte_index = '0;

		// Directed requests: field extremes, each command and the corner cases.
		// Read right after reset must see a cleared store.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
		// Corner pixels set, and the far corner cleared again.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_PIXEL, 0, 0, 0, 0, 1, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_PIXEL, 127, 63, 0, 0, 1, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_PIXEL, 127, 63, 0, 0, 0, 1023));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 1023));
		// Rows past the screen bottom would alias onto on-screen pages if not skipped.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_PIXEL, 5, 64, 0, 0, 1, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_PIXEL, 6, 127, 127, 127, 1, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 5));
		// Full-width horizontal run and full-height vertical run.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 0, 10, 127, 10, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 192));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 3, 0, 3, 63, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 899));
		// Backward horizontal and vertical runs draw nothing.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 100, 20, 50, 20, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 50, 40, 50, 30, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 331));
		// Falling slope stays on its start row; steep slope leaves gaps.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 10, 30, 20, 5, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 399));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 60, 0, 62, 50, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 62));
		// Backward sloped line, and a slope that runs off the bottom edge.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 90, 8, 80, 20, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_LINE, 0, 60, 127, 127, 0, 0));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 900));
		// Clear wipes everything drawn so far.
		directed_reqs.push_back(req_of(fbld_pkg::REQ_CLEAR, 127, 127, 127, 127, 1, 1023));
		directed_reqs.push_back(req_of(fbld_pkg::REQ_READ, 0, 0, 0, 0, 0, 899));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bursts of back-to-back requests separated by random idle gaps; about a
		// quarter of the bursts run straight into the next one.
		total = directed_reqs.size() + RANDOM_ITEMS;
		while (items_sent < total) begin
			burst = $urandom_range(1, 40);
			for (i = 0; i < burst && items_sent < total; i++) begin
				if (directed_reqs.size() != 0) begin
					r = directed_reqs.pop_front();
				end else begin
					make_random_request(r);
				end
				drive_request(r);
				items_sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		cmd_valid <= 1'b0;

		// Wait for every owed response, then let the block settle.
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("framebuffer_line_drawer_unit: match");
		end else begin
			$display("framebuffer_line_drawer_unit: mismatch");
		end
		$finish;
	end

endmodule
